>>> sv/slc_pkg.sv
// Shared types and constants for the slew-limited joint command block.
// Holds angle and step types, register indexes and phase codes; no dependencies.
package slc_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned JIDX_W  = 5;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic        [ANGLE_W-1:0] mag_t;
  typedef logic        [STEP_W-1:0]  step_t;
  typedef logic        [COUNT_W-1:0] count_t;

  // Configuration register indexes (byte address / 4)
  localparam logic [2:0] REG_TRACKING_STEP = 3'd0;
  localparam logic [2:0] REG_RETURN_STEP   = 3'd1;
  localparam logic [2:0] REG_TIMEOUT       = 3'd2;
  localparam logic [2:0] REG_GRACE         = 3'd3;
  localparam logic [2:0] REG_ZERO_THRESH   = 3'd4;

  // Reset values of the configuration registers
  localparam step_t  TRACKING_STEP_RST = 15'd246;
  localparam step_t  RETURN_STEP_RST   = 15'd41;
  localparam count_t TIMEOUT_RST       = 16'd50;
  localparam count_t GRACE_RST         = 16'd30;
  localparam step_t  ZERO_THRESH_RST   = 15'd4;

  // Input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Phase codes reported on the last result of a tick
  localparam logic [1:0] PHASE_TRACK     = 2'd0;
  localparam logic [1:0] PHASE_HOLD      = 2'd1;
  localparam logic [1:0] PHASE_RETURNING = 2'd2;
  localparam logic [1:0] PHASE_ZERO_HOLD = 2'd3;

  localparam count_t COUNT_MAX = '1;

endpackage

>>> sv/slc_slew.sv
// Shared slew unit: moves one command toward its goal by a clamped step.
// Used once per joint by the tick sequencer; depends on slc_pkg.
module slc_slew (
  input  slc_pkg::angle_t cur_i,
  input  slc_pkg::angle_t goal_i,
  input  slc_pkg::step_t  step_i,
  output slc_pkg::angle_t next_o,
  output slc_pkg::mag_t   mag_o
);
  import slc_pkg::*;

  logic signed [ANGLE_W:0] delta;
  logic signed [ANGLE_W:0] step_pos;
  logic signed [ANGLE_W:0] step_neg;
  logic signed [ANGLE_W:0] delta_clamped;
  logic signed [ANGLE_W:0] sum;
  logic signed [ANGLE_W:0] neg_sum;

  // Difference to goal, widened by one bit so it cannot wrap
  assign delta    = {goal_i[ANGLE_W-1], goal_i} - {cur_i[ANGLE_W-1], cur_i};
  assign step_pos = {2'b00, step_i};
  assign step_neg = -step_pos;

  // Clamp the change to the allowed step
  always_comb begin
    priority if (delta > step_pos) begin
      delta_clamped = step_pos;
    end else if (delta < step_neg) begin
      delta_clamped = step_neg;
    end else begin
      delta_clamped = delta;
    end
  end

  // New command stays between old value and goal, so the low bits hold it
  assign sum     = {cur_i[ANGLE_W-1], cur_i} + delta_clamped;
  assign next_o  = sum[ANGLE_W-1:0];
  assign neg_sum = -sum;
  assign mag_o   = sum[ANGLE_W] ? neg_sum[ANGLE_W-1:0] : sum[ANGLE_W-1:0];

endmodule

>>> sv/slew_limited_joint_command_top.sv
// Top level of the slew-limited joint command block: APB registers, frame and
// tracking counters, target and command stores, and the tick sequencer.
// Depends on slc_pkg and slc_slew.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------------------
//  in      | into      | in_valid_i / in_stall_o | opcode, joint_index, target_angle,
//          |           |                         | frame_done, teleop_active
//  out     | out of    | out_valid_o/out_stall_i | joint_number, command_angle, last_joint,
//          |           |                         | phase, tracking_on, frame_stale, peak_abs
//  cfg     | into      | APB psel/penable/pready | five registers at byte address 4*i
//
// A tick runs a first pass through the one shared slew unit, each joint taking a
// store read, then update and write, then a second pass per result: store read,
// output register load, transfer; output stalls hold the second pass.
// Reset clears the registers, counters and the command valid bits; commands
// read as zero until first written, so no clearing pass is needed.
// in_stall_o is high from the accepted tick until its last result is taken.
module slew_limited_joint_command_top #(
  parameter int unsigned JOINTS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     opcode_i,
  input  logic [slc_pkg::JIDX_W-1:0] joint_index_i,
  input  slc_pkg::angle_t          target_angle_i,
  input  logic                     frame_done_i,
  input  logic                     teleop_active_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [slc_pkg::JIDX_W-1:0] joint_number_o,
  output slc_pkg::angle_t          command_angle_o,
  output logic                     last_joint_o,
  output logic [1:0]               phase_o,
  output logic                     tracking_on_o,
  output logic                     frame_stale_o,
  output slc_pkg::mag_t            peak_abs_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [slc_pkg::PADDR_W-1:0] paddr,
  input  logic [slc_pkg::PDATA_W-1:0] pwdata,
  output logic [slc_pkg::PDATA_W-1:0] prdata,
  output logic                     pready
);
  import slc_pkg::*;

  localparam int unsigned IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(JOINTS - 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_OFETCH = 3'd3;
  localparam logic [2:0] S_OLOAD  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  // Configuration registers
  step_t  trk_step_q, ret_step_q, zero_thr_q;
  count_t timeout_q, grace_q;

  // Frame and tracking state
  logic   have_frame_q;
  count_t frame_age_q, since_trk_q;

  // Tick context
  logic   trk_q, hold_q, stale_q;
  mag_t   peak_q;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  // Stores and their registered read data
  angle_t           tgt_mem [JOINTS];
  angle_t           cmd_mem [JOINTS];
  logic [JOINTS-1:0] cmd_vld_q;
  angle_t           tgt_rdata_q, cmd_rdata_q;
  logic             cmd_vld_rd_q;

  // Output registers
  logic [JIDX_W-1:0] jnum_q;
  angle_t            cmd_out_q;
  logic              last_q;
  logic [1:0]        phase_q;
  logic              trk_out_q, stale_out_q;
  mag_t              peak_out_q;

  logic   in_accept, out_accept, cfg_write;
  logic   is_load, is_tick;
  logic   stale_now, trk_now, hold_now;
  logic   load_in_range;
  angle_t cur, goal, next_cmd;
  mag_t   mag;
  step_t  step_sel;
  logic [1:0] phase_now;
  logic   is_last;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_accept  = out_valid_o && !out_stall_i;
  assign is_load     = in_accept && (opcode_i == OP_LOAD);
  assign is_tick     = in_accept && (opcode_i == OP_TICK);
  assign is_last     = (idx_q == LAST_IDX);

  assign load_in_range = ({1'b0, joint_index_i} < (JIDX_W + 1)'(JOINTS));

  // Mode decision from the counters as they stand when the tick arrives
  assign stale_now = !have_frame_q || (frame_age_q > timeout_q);
  assign trk_now   = teleop_active_i && !stale_now;
  assign hold_now  = !trk_now && (since_trk_q < grace_q);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_step_q <= TRACKING_STEP_RST;
      ret_step_q <= RETURN_STEP_RST;
      timeout_q  <= TIMEOUT_RST;
      grace_q    <= GRACE_RST;
      zero_thr_q <= ZERO_THRESH_RST;
    end else if (cfg_write) begin
      unique case (paddr[4:2])
        REG_TRACKING_STEP: trk_step_q <= pwdata[STEP_W-1:0];
        REG_RETURN_STEP:   ret_step_q <= pwdata[STEP_W-1:0];
        REG_TIMEOUT:       timeout_q  <= pwdata[COUNT_W-1:0];
        REG_GRACE:         grace_q    <= pwdata[COUNT_W-1:0];
        REG_ZERO_THRESH:   zero_thr_q <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_TRACKING_STEP: prdata = PDATA_W'(trk_step_q);
      REG_RETURN_STEP:   prdata = PDATA_W'(ret_step_q);
      REG_TIMEOUT:       prdata = PDATA_W'(timeout_q);
      REG_GRACE:         prdata = PDATA_W'(grace_q);
      REG_ZERO_THRESH:   prdata = PDATA_W'(zero_thr_q);
      default:           prdata = '0;
    endcase
  end

  // Frame age and ticks since tracking; both saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_frame_q <= 1'b0;
      frame_age_q  <= '0;
      since_trk_q  <= '0;
      trk_q        <= 1'b0;
      hold_q       <= 1'b0;
      stale_q      <= 1'b0;
    end else if (is_load) begin
      if (frame_done_i) begin
        have_frame_q <= 1'b1;
        frame_age_q  <= '0;
      end
    end else if (is_tick) begin
      trk_q   <= trk_now;
      hold_q  <= hold_now;
      stale_q <= stale_now;
      if (frame_age_q != COUNT_MAX) begin
        frame_age_q <= frame_age_q + count_t'(1);
      end
      if (trk_now) begin
        since_trk_q <= count_t'(1);
      end else if (since_trk_q != COUNT_MAX) begin
        since_trk_q <= since_trk_q + count_t'(1);
      end
    end
  end

  // Target store: written by load transfers, read by the first pass
  always_ff @(posedge clk_i) begin
    if (is_load && load_in_range) begin
      tgt_mem[joint_index_i[IDX_W-1:0]] <= target_angle_i;
    end
    tgt_rdata_q <= tgt_mem[idx_q];
  end

  // Command store: updated by the first pass, read by both passes
  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) begin
      cmd_mem[idx_q] <= next_cmd;
    end
    cmd_rdata_q  <= cmd_mem[idx_q];
    cmd_vld_rd_q <= cmd_vld_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= '0;
    end else if (state_q == S_CALC) begin
      cmd_vld_q[idx_q] <= 1'b1;
    end
  end

  // Goal and step for the shared slew unit
  assign cur      = cmd_vld_rd_q ? cmd_rdata_q : '0;
  assign goal     = trk_q ? tgt_rdata_q : (hold_q ? cur : '0);
  assign step_sel = trk_q ? trk_step_q : ret_step_q;

  slc_slew u_slew (
    .cur_i  (cur),
    .goal_i (goal),
    .step_i (step_sel),
    .next_o (next_cmd),
    .mag_o  (mag)
  );

  // Track the peak magnitude over the first pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else if (is_tick) begin
      peak_q <= '0;
    end else if ((state_q == S_CALC) && (mag > peak_q)) begin
      peak_q <= mag;
    end
  end

  always_comb begin
    priority if (trk_q) begin
      phase_now = PHASE_TRACK;
    end else if (hold_q) begin
      phase_now = PHASE_HOLD;
    end else if (peak_q > {1'b0, zero_thr_q}) begin
      phase_now = PHASE_RETURNING;
    end else begin
      phase_now = PHASE_ZERO_HOLD;
    end
  end

  // Load the output registers from the settled command store
  always_ff @(posedge clk_i) begin
    if (state_q == S_OLOAD) begin
      jnum_q      <= JIDX_W'(idx_q);
      cmd_out_q   <= cur;
      last_q      <= is_last;
      phase_q     <= is_last ? phase_now : PHASE_TRACK;
      trk_out_q   <= trk_q;
      stale_out_q <= stale_q;
      peak_out_q  <= is_last ? peak_q : '0;
    end
  end

  assign joint_number_o  = jnum_q;
  assign command_angle_o = cmd_out_q;
  assign last_joint_o    = last_q;
  assign phase_o         = phase_q;
  assign tracking_on_o   = trk_out_q;
  assign frame_stale_o   = stale_out_q;
  assign peak_abs_o      = peak_out_q;

  // Tick sequencer: update pass, then emit pass
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_tick) begin
          state_d = S_FETCH;
          idx_d   = '0;
        end
      end
      S_FETCH: state_d = S_CALC;
      S_CALC: begin
        if (is_last) begin
          state_d = S_OFETCH;
          idx_d   = '0;
        end else begin
          state_d = S_FETCH;
          idx_d   = idx_q + IDX_W'(1);
        end
      end
      S_OFETCH: state_d = S_OLOAD;
      S_OLOAD:  state_d = S_OUT;
      S_OUT: begin
        if (out_accept) begin
          if (last_q) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_OFETCH;
            idx_d   = idx_q + IDX_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for slew_limited_joint_command_top: queued driver, output monitor,
// APB register setup and a per-transfer predictor of the joint slew logic.
// Depends on slc_pkg and the block's RTL.
module tb_top;
  import slc_pkg::*;

  localparam int JOINTS      = 20;
  localparam int TICK_CYCLES = 5 * JOINTS + 1;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int CHUNK_ITEMS = 50;

  typedef struct packed {
    logic              op;
    logic [JIDX_W-1:0] jidx;
    angle_t            angle;
    logic              fdone;
    logic              teleop;
  } joint_item_t;

  typedef struct packed {
    logic [JIDX_W-1:0] joint;
    angle_t            angle;
    logic              last;
    logic [1:0]        phase;
    logic              trk;
    logic              stale;
    mag_t              peak;
  } cmd_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic              opcode_i        = OP_LOAD;
  logic [JIDX_W-1:0] joint_index_i   = '0;
  angle_t            target_angle_i  = '0;
  logic              frame_done_i    = 1'b0;
  logic              teleop_active_i = 1'b0;

  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic [JIDX_W-1:0] joint_number_o;
  angle_t            command_angle_o;
  logic              last_joint_o;
  logic [1:0]        phase_o;
  logic              tracking_on_o;
  logic              frame_stale_o;
  mag_t              peak_abs_o;

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Predictor state: configuration copy, stores and counters
  step_t  trk_step_cfg   = TRACKING_STEP_RST;
  step_t  ret_step_cfg   = RETURN_STEP_RST;
  count_t timeout_cfg    = TIMEOUT_RST;
  count_t grace_cfg      = GRACE_RST;
  step_t  zero_thr_cfg   = ZERO_THRESH_RST;
  angle_t joint_targets  [JOINTS];
  angle_t cmd_pred       [JOINTS];
  logic   have_frame     = 1'b0;
  count_t frame_age      = '0;
  count_t since_tracking = '0;

  joint_item_t pending_items[$];
  joint_item_t offered;
  cmd_result_t expected_commands[$];

  int error_count   = 0;
  int stim_count    = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  slew_limited_joint_command_top #(.JOINTS(JOINTS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .joint_index_i   (joint_index_i),
    .target_angle_i  (target_angle_i),
    .frame_done_i    (frame_done_i),
    .teleop_active_i (teleop_active_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .joint_number_o  (joint_number_o),
    .command_angle_o (command_angle_o),
    .last_joint_o    (last_joint_o),
    .phase_o         (phase_o),
    .tracking_on_o   (tracking_on_o),
    .frame_stale_o   (frame_stale_o),
    .peak_abs_o      (peak_abs_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one accepted item to the predicted state; a tick queues one command per joint
  function automatic void step_slew_model(input joint_item_t it);
    logic        stale;
    logic        trk;
    logic        hold;
    logic [1:0]  ph;
    int          step;
    int          cur;
    int          goal;
    int          delta;
    int          mag;
    int          peak;
    cmd_result_t r;
    if (it.op == OP_LOAD) begin
      if (it.jidx < JOINTS) joint_targets[it.jidx] = it.angle;
      if (it.fdone) begin
        have_frame = 1'b1;
        frame_age  = '0;
      end
    end else begin
      stale = !have_frame || (frame_age > timeout_cfg);
      trk   = it.teleop && !stale;
      if (trk) since_tracking = '0;
      hold  = !trk && (since_tracking < grace_cfg);
      step  = trk ? int'(trk_step_cfg) : int'(ret_step_cfg);
      peak  = 0;
      // move every command toward its goal by at most one step
      for (int i = 0; i < JOINTS; i++) begin
        cur   = int'(cmd_pred[i]);
        goal  = trk ? int'(joint_targets[i]) : (hold ? cur : 0);
        delta = goal - cur;
        if (delta > step) delta = step;
        if (delta < -step) delta = -step;
        cur = cur + delta;
        cmd_pred[i] = angle_t'(cur);
        mag = (cur < 0) ? -cur : cur;
        if (mag > peak) peak = mag;
      end
      if (trk) ph = PHASE_TRACK;
      else if (hold) ph = PHASE_HOLD;
      else if (peak > int'(zero_thr_cfg)) ph = PHASE_RETURNING;
      else ph = PHASE_ZERO_HOLD;
      for (int i = 0; i < JOINTS; i++) begin
        r.joint = i[JIDX_W-1:0];
        r.angle = cmd_pred[i];
        r.last  = (i == JOINTS - 1);
        r.phase = r.last ? ph : '0;
        r.trk   = trk;
        r.stale = stale;
        r.peak  = r.last ? peak[15:0] : '0;
        expected_commands.push_back(r);
      end
      if (frame_age != COUNT_MAX) frame_age = frame_age + count_t'(1);
      if (since_tracking != COUNT_MAX) since_tracking = since_tracking + count_t'(1);
    end
  endfunction

  // Driver: predict on each transfer, then offer the next pending item or idle
  always @(posedge clk_i) begin : drive_proc
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) step_slew_model(offered);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered          = pending_items.pop_front();
          opcode_i        <= offered.op;
          joint_index_i   <= offered.jidx;
          target_angle_i  <= offered.angle;
          frame_done_i    <= offered.fdone;
          teleop_active_i <= offered.teleop;
          in_valid_i      <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expected command
  always @(posedge clk_i) begin : watch_proc
    cmd_result_t got;
    cmd_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{joint: joint_number_o, angle: command_angle_o, last: last_joint_o,
                phase: phase_o, trk: tracking_on_o, stale: frame_stale_o,
                peak: peak_abs_o};
        if (expected_commands.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: joint %0d angle %0d", got.joint, got.angle);
        end else begin
          want = expected_commands.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= 10)
              $display({"mismatch exp joint %0d ang %0d last %0b ph %0d trk %0b ",
                        "stale %0b pk %0d / act joint %0d ang %0d last %0b ph %0d ",
                        "trk %0b stale %0b pk %0d"},
                       want.joint, want.angle, want.last, want.phase, want.trk, want.stale,
                       want.peak, got.joint, got.angle, got.last, got.phase, got.trk,
                       got.stale, got.peak);
          end
        end
      end
      if (hold_left != 0) out_stall_i <= 1'b1;
      else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_requests;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [PDATA_W-1:0] cfg_value(input logic [2:0] idx);
    case (idx)
      REG_TRACKING_STEP: return PDATA_W'(trk_step_cfg);
      REG_RETURN_STEP:   return PDATA_W'(ret_step_cfg);
      REG_TIMEOUT:       return PDATA_W'(timeout_cfg);
      REG_GRACE:         return PDATA_W'(grace_cfg);
      default:           return PDATA_W'(zero_thr_cfg);
    endcase
  endfunction

  // Write a register and mirror it; bits above the register width drop, unknown indexes do nothing
  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] data);
    apb_write({idx, 2'b00}, data);
    case (idx)
      REG_TRACKING_STEP: trk_step_cfg = data[STEP_W-1:0];
      REG_RETURN_STEP:   ret_step_cfg = data[STEP_W-1:0];
      REG_TIMEOUT:       timeout_cfg  = data[COUNT_W-1:0];
      REG_GRACE:         grace_cfg    = data[COUNT_W-1:0];
      REG_ZERO_THRESH:   zero_thr_cfg = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_regs();
    logic [PDATA_W-1:0] rd;
    for (int k = 0; k <= int'(REG_ZERO_THRESH); k++) begin
      apb_read({k[2:0], 2'b00}, rd);
      if (rd !== cfg_value(k[2:0])) begin
        error_count++;
        if (error_count <= 10)
          $display("register %0d readback exp %0d act %0d", k, cfg_value(k[2:0]), rd);
      end
    end
  endtask

  // Program all five registers with junk above each register's width, then read back
  task automatic program_config(input int ts, input int rs, input int to, input int gr,
                                input int zt);
    int vals [5];
    int shift;
    vals = '{ts, rs, to, gr, zt};
    for (int k = 0; k < 5; k++) begin
      shift = (k == int'(REG_TIMEOUT) || k == int'(REG_GRACE)) ? COUNT_W : STEP_W;
      write_reg(k[2:0], PDATA_W'(vals[k]) | ($urandom << shift));
    end
    check_regs();
  endtask

  task automatic push_item(input logic op, input int jidx, input int angle, input logic fd,
                           input logic tp);
    joint_item_t it;
    it.op     = op;
    it.jidx   = jidx[JIDX_W-1:0];
    it.angle  = angle[15:0];
    it.fdone  = fd;
    it.teleop = tp;
    pending_items.push_back(it);
    // a load to a missing joint without a frame mark changes nothing
    if (!(op == OP_LOAD && jidx >= JOINTS && !fd)) stim_count++;
  endtask

  task automatic push_tick(input logic tp);
    push_item(OP_TICK, $urandom_range(31), $urandom, 1'($urandom_range(1)), tp);
  endtask

  // One full target frame, frame mark on the last joint
  task automatic queue_frame();
    int a;
    for (int j = 0; j < JOINTS; j++) begin
      a = ($urandom_range(1) != 0) ? int'($urandom) : int'($urandom_range(400)) - 200;
      push_item(OP_LOAD, j, a, j == JOINTS - 1, 1'($urandom_range(1)));
    end
  endtask

  task automatic queue_random_burst();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 45) begin
      queue_frame();
      n = $urandom_range(1, 4);
      repeat (n) push_tick($urandom_range(99) < 85);
    end else if (kind < 70) begin
      n = $urandom_range(1, 10);
      repeat (n) push_tick($urandom_range(99) < 70);
    end else if (kind < 85) begin
      n = $urandom_range(1, 6);
      repeat (n)
        push_item(OP_LOAD, $urandom_range(31), $urandom, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end else begin
      n = $urandom_range(4, 16);
      repeat (n) push_tick(1'b0);
    end
  endtask

  // Queue random sequences under one idling mode and wait until they are all offered
  task automatic run_chunk(input int mode, input logic long_hold);
    int start;
    @(negedge clk_i);
    case (mode)
      1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
      3:       begin send_idle_pct = 14; recv_stall_pct = 14; end
      default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    start = stim_count;
    while (stim_count - start < CHUNK_ITEMS) queue_random_burst();
    if (long_hold) hold_requests++;
    while (pending_items.size() != 0) @(negedge clk_i);
  endtask

  // Hold off until every expected command has arrived and the block has settled
  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_commands.size() != 0)
      @(negedge clk_i);
    repeat (TICK_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    foreach (cmd_pred[j]) cmd_pred[j] = '0;
    foreach (joint_targets[j]) joint_targets[j] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    // Directed: tick with no frame, full frame with extreme angles, missing joints, mode walk
    @(negedge clk_i);
    push_tick(1'b1);
    push_item(OP_LOAD, 0, 32767, 1'b0, 1'b0);
    push_item(OP_LOAD, 1, -32768, 1'b0, 1'b1);
    push_item(OP_LOAD, 2, 0, 1'b0, 1'b0);
    push_item(OP_LOAD, 3, -1, 1'b0, 1'b1);
    push_item(OP_LOAD, 4, 1, 1'b0, 1'b0);
    for (int j = 5; j < JOINTS - 1; j++)
      push_item(OP_LOAD, j, $urandom, 1'b0, 1'($urandom_range(1)));
    push_item(OP_LOAD, JOINTS - 1, -32768, 1'b1, 1'b0);
    push_item(OP_LOAD, 31, 16'h5555, 1'b0, 1'b0);
    push_item(OP_LOAD, JOINTS, 16'h2aaa, 1'b1, 1'b1);
    push_tick(1'b1);
    push_tick(1'b1);
    push_tick(1'b0);
    push_tick(1'b0);
    drain();

    // Reset configuration
    run_chunk(0, 1'b0);
    run_chunk(1, 1'b0);
    drain();

    // Largest steps, instant staleness, no grace window, zero threshold
    program_config(32767, 32767, 0, 0, 0);
    for (int k = int'(REG_ZERO_THRESH) + 1; k < 8; k++) write_reg(k[2:0], $urandom);
    check_regs();
    run_chunk(2, 1'b0);
    run_chunk(3, 1'b0);
    drain();

    // Short timeout and grace so every phase comes up often; long receiver hold-off
    program_config(300, 150, 4, 3, 1000);
    run_chunk(0, 1'b1);
    run_chunk(1, 1'b0);
    run_chunk(2, 1'b0);
    drain();

    // Frozen commands, counters that never expire
    program_config(0, 0, 65535, 65535, 32767);
    run_chunk(3, 1'b0);
    drain();

    // Random mid-range settings
    program_config($urandom_range(1, 2000), $urandom_range(1, 500), $urandom_range(12),
                   $urandom_range(8), $urandom_range(3000));
    run_chunk(0, 1'b0);
    run_chunk(2, 1'b0);
    drain();

    if (error_count == 0 && expected_commands.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
